@@ hw/rtl/csrb_pkg.sv @@
// Shared types, codes and sizes for the crossfade sample ring buffer.
package csrb_pkg;

  // Store geometry
  localparam int DEPTH    = 8192;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CAP_W    = IDX_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = $clog2(SAMPLE_W);
  localparam int REM_W    = CAP_W + 1;
  localparam int ACC_W    = REM_W + SAMPLE_W;
  localparam int QS_W     = SAMPLE_W + 2;

  // Action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FADE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  // Crossfade modes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_HOLD   = 1'b1;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [1:0]                 status;
    logic                       fading;
  } res_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] old;
    logic signed [SAMPLE_W-1:0] smp;
    logic [CAP_W-1:0]           remain;
    logic [CAP_W-1:0]           pos;
    logic [CAP_W-1:0]           cap;
    logic                       hmode;
  } mix_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
  } mix_rsp_t;

endpackage

@@ hw/rtl/csrb_mixer.sv @@
// Bit-serial crossfade mixer: shift-add multiply, then restoring divide by capacity.
module csrb_mixer
  import csrb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  mix_req_t req,
  output mix_rsp_t rsp
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_MUL  = 5'b00010,
    M_PREP = 5'b00100,
    M_DIV  = 5'b01000,
    M_DONE = 5'b10000
  } mstate_t;

  mstate_t                    mstate;
  mix_req_t                   req_q;
  logic signed [ACC_W-1:0]    acc;
  logic [STEP_W-1:0]          step;
  logic                       neg;
  logic [REM_W-1:0]           rem;
  logic [SAMPLE_W-1:0]        quo;
  logic                       done_q;
  logic signed [SAMPLE_W-1:0] value;

  logic signed [ACC_W-1:0]    add_old;
  logic signed [ACC_W-1:0]    add_smp;
  logic signed [ACC_W-1:0]    acc_next;
  logic [ACC_W-1:0]           mag;
  logic [REM_W-1:0]           trial;
  logic [REM_W-1:0]           cap_ext;
  logic                       ge;
  logic signed [QS_W-1:0]     qs;
  logic signed [QS_W-1:0]     sum;
  logic signed [SAMPLE_W-1:0] sat;

  // One multiplier bit of the remaining weight and, in linear mode, of pos per cycle, MSB first
  always_comb begin
    add_old = req_q.remain[step] ?
              {{(ACC_W-SAMPLE_W){req_q.old[SAMPLE_W-1]}}, req_q.old} : '0;
    add_smp = (!req_q.hmode && req_q.pos[step]) ?
              {{(ACC_W-SAMPLE_W){req_q.smp[SAMPLE_W-1]}}, req_q.smp} : '0;
    acc_next = (acc <<< 1) + add_old + add_smp;
    mag      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  end

  // One quotient bit per cycle
  always_comb begin
    cap_ext = {1'b0, req_q.cap};
    trial   = {rem[REM_W-2:0], quo[SAMPLE_W-1]};
    ge      = trial >= cap_ext;
  end

  // Apply sign, add the new sample in H mode, saturate
  always_comb begin
    qs  = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    sum = qs + (req_q.hmode ? {{(QS_W-SAMPLE_W){req_q.smp[SAMPLE_W-1]}}, req_q.smp}
                            : QS_W'(0));
    if (sum > QS_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -QS_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  // Sequence multiply, prepare, divide, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (mstate)
        M_IDLE: begin
          if (start) begin
            req_q  <= req;
            acc    <= '0;
            step   <= STEP_W'(CAP_W - 1);
            mstate <= M_MUL;
          end
        end
        M_MUL: begin
          acc <= acc_next;
          if (step == '0) begin
            mstate <= M_PREP;
          end else begin
            step <= step - 1'b1;
          end
        end
        M_PREP: begin
          neg    <= acc[ACC_W-1];
          rem    <= mag[ACC_W-1:SAMPLE_W];
          quo    <= mag[SAMPLE_W-1:0];
          step   <= STEP_W'(SAMPLE_W - 1);
          mstate <= M_DIV;
        end
        M_DIV: begin
          rem <= ge ? trial - cap_ext : trial;
          quo <= {quo[SAMPLE_W-2:0], ge};
          if (step == '0) begin
            mstate <= M_DONE;
          end else begin
            step <= step - 1'b1;
          end
        end
        M_DONE: begin
          value  <= sat;
          done_q <= 1'b1;
          mstate <= M_IDLE;
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp.done  = done_q;
  assign rsp.value = value;

endmodule

@@ hw/rtl/crossfade_sample_ring_buffer.sv @@
// Crossfading ring FIFO of audio samples with APB register port and serial mixer.
//
//   channel | handshake                    | word
//   --------+------------------------------+--------------------------------
//   cmd     | cmd_valid / cmd_ready        | cmd_t: action, sample_in
//   res     | res_valid / res_ready        | res_t: sample_out, status, fading
//   config  | psel, penable, pwrite, pready| 32-bit registers at 0x0, 0x4, 0x8
//
// Plain reads, writes, refusals and crossfade starts go from accept through fetch
// and finish to the output register; faded writes also run the mixer's 14 multiply
// and 16 divide steps. A new word is accepted only in idle. After reset a clearing
// pass zeroes the 8192-entry store, one entry a cycle, with cmd_ready low; register
// writes are taken. A stalled result holds in the output register; the next word is
// accepted meanwhile and its commit waits until the output register frees.
module crossfade_sample_ring_buffer
  import csrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_MIX    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           clr_addr;
  logic [SAMPLE_W-1:0]        store [DEPTH];
  logic [SAMPLE_W-1:0]        rd_data;

  logic [IDX_W-1:0]           read_index;
  logic [IDX_W-1:0]           write_index;
  logic [CAP_W-1:0]           held_count;
  logic                       fade_active;

  logic [1:0]                 ch_reg;
  logic                       mode_reg;
  logic [CAP_W-1:0]           cap_reg;

  logic [1:0]                 act_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [1:0]                 status_q;
  logic signed [SAMPLE_W-1:0] out_smp_q;
  logic signed [SAMPLE_W-1:0] wr_val;

  logic                       ch2;
  logic [CAP_W-1:0]           lim;
  logic [CAP_W-1:0]           cap;
  logic [CAP_W-1:0]           slots;
  logic [CAP_W-1:0]           chn;
  logic                       full;
  logic [CAP_W-1:0]           pos;
  logic [CAP_W-1:0]           remain;
  logic [CAP_W-1:0]           held_inc;
  logic [CAP_W-1:0]           np;
  logic                       fade_end;
  logic [CAP_W-1:0]           wr_inc;
  logic [CAP_W-1:0]           rd_inc;
  logic [IDX_W-1:0]           write_index_next;
  logic [IDX_W-1:0]           read_index_next;
  logic                       cmd_fire;
  logic                       commit;
  logic                       commit_ok;
  logic                       fade_after;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;
  logic                       mix_start;
  mix_req_t                   mix_req;
  mix_rsp_t                   mix_rsp;

  // Effective channel count, clamped capacity and slot count
  always_comb begin
    ch2   = ch_reg[1];
    lim   = ch2 ? CAP_W'(DEPTH / 2) : CAP_W'(DEPTH);
    if (cap_reg < CAP_W'(2)) begin
      cap = CAP_W'(2);
    end else if (cap_reg > lim) begin
      cap = lim;
    end else begin
      cap = cap_reg;
    end
    slots  = ch2 ? {cap[CAP_W-2:0], 1'b0} : cap;
    chn    = ch2 ? CAP_W'(2) : CAP_W'(1);
    full   = held_count >= (slots - chn);
    pos    = ch2 ? (held_count >> 1) : held_count;
    remain = (pos >= cap) ? '0 : cap - pos;
  end

  // Fill after a write, fade end test and index wrap
  always_comb begin
    held_inc         = held_count + 1'b1;
    np               = ch2 ? (held_inc >> 1) : held_inc;
    fade_end         = (np + 1'b1) >= cap;
    wr_inc           = {1'b0, write_index} + 1'b1;
    rd_inc           = {1'b0, read_index} + 1'b1;
    write_index_next = (wr_inc >= slots) ? '0 : wr_inc[IDX_W-1:0];
    read_index_next  = (rd_inc >= slots) ? '0 : rd_inc[IDX_W-1:0];
  end

  assign cmd_ready = (state == S_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign commit    = (state == S_FINISH) && (!res_valid || res_ready);
  assign commit_ok = commit && (status_q == ST_DONE);

  // Fade flag as it stands after the committed word
  always_comb begin
    fade_after = fade_active;
    if (commit_ok && act_q == ACT_WRITE && fade_active && fade_end) begin
      fade_after = 1'b0;
    end else if (commit_ok && act_q != ACT_WRITE && act_q != ACT_READ) begin
      fade_after = 1'b1;
    end
  end

  // Sample store: clearing pass, committed writes, read on accept
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      store[clr_addr] <= '0;
    end else if (commit_ok && act_q == ACT_WRITE) begin
      store[write_index] <= wr_val;
    end
    if (cmd_fire) begin
      rd_data <= store[(cmd.action == ACT_WRITE) ? write_index : read_index];
    end
  end

  // Mixer request
  always_comb begin
    mix_req.old    = rd_data;
    mix_req.smp    = smp_q;
    mix_req.remain = remain;
    mix_req.pos    = pos;
    mix_req.cap    = cap;
    mix_req.hmode  = mode_reg;
  end

  assign mix_start = (state == S_FETCH) && (act_q == ACT_WRITE) && !full && fade_active;

  csrb_mixer u_mixer (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .req   (mix_req),
    .rsp   (mix_rsp)
  );

  // Sequencer: decide in fetch, mix writes while fading, commit when output frees
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_fire) begin
            act_q <= cmd.action;
            smp_q <= cmd.sample_in;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          out_smp_q <= '0;
          status_q  <= ST_DONE;
          wr_val    <= smp_q;
          state     <= S_FINISH;
          case (act_q)
            ACT_WRITE: begin
              if (full) begin
                status_q <= ST_FULL;
              end else if (fade_active) begin
                state <= S_MIX;
              end
            end
            ACT_READ: begin
              if (held_count == '0) begin
                status_q <= ST_EMPTY;
              end else begin
                out_smp_q <= rd_data;
              end
            end
            default: begin
              if (fade_active) begin
                status_q <= ST_IGNORED;
              end
            end
          endcase
        end
        S_MIX: begin
          if (mix_rsp.done) begin
            wr_val <= mix_rsp.value;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.sample_out <= out_smp_q;
      res.status     <= status_q;
      res.fading     <= fade_after;
    end
  end

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_CHANNELS: prdata = {30'd0, ch_reg};
      REG_MODE:     prdata = {31'd0, mode_reg};
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, cap_reg};
      default:      prdata = '0;
    endcase
  end

  // Buffer state: commit updates, channel and capacity register writes empty the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      held_count  <= '0;
      fade_active <= 1'b0;
      ch_reg      <= 2'd2;
      mode_reg    <= 1'b0;
      cap_reg     <= CAP_W'(4096);
    end else begin
      if (commit_ok) begin
        fade_active <= fade_after;
        case (act_q)
          ACT_WRITE: begin
            write_index <= write_index_next;
            held_count  <= held_inc;
          end
          ACT_READ: begin
            read_index <= read_index_next;
            held_count <= held_count - 1'b1;
          end
          default: begin
            write_index <= read_index;
            held_count  <= '0;
          end
        endcase
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_CHANNELS: begin
            ch_reg      <= pwdata[1:0];
            read_index  <= '0;
            write_index <= '0;
            held_count  <= '0;
            fade_active <= 1'b0;
          end
          REG_MODE: begin
            mode_reg <= pwdata[0];
          end
          REG_CAPACITY: begin
            cap_reg     <= pwdata[CAP_W-1:0];
            read_index  <= '0;
            write_index <= '0;
            held_count  <= '0;
            fade_active <= 1'b0;
          end
          default: begin
            mode_reg <= mode_reg;
          end
        endcase
      end
    end
  end

  // Checks
  a_held_below_slots: assert property (@(posedge clk) disable iff (rst)
    held_count < slots)
    else $error("held count reached slot count");

  a_empty_reads_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_EMPTY) |-> (res.sample_out == '0))
    else $error("refused read carries a sample");

  a_mix_done_in_mix: assert property (@(posedge clk) disable iff (rst)
    mix_rsp.done |-> (state == S_MIX))
    else $error("mixer finished outside mix state");

  a_read_drops_fill: assert property (@(posedge clk) disable iff (rst)
    commit_ok && (act_q == ACT_READ) && !cfg_wr |=>
    (held_count == $past(held_count) - 1'b1))
    else $error("read did not drop the fill");

endmodule
